>>> hw/rtl/aqg_pkg.sv
// Shared types, constants and codes for the adaptive quality governor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package aqg_pkg;

	localparam int WINDOW     = 60;
	localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W     = $clog2(WINDOW + 1);
	localparam int FT_W       = 20;
	localparam int SAMPLE_W   = 28;
	localparam int SUM_W      = SAMPLE_W + FILL_W;
	localparam int CMP_W      = SUM_W + 5;
	localparam int INTERVAL_W = 26;
	localparam int TIMER_W    = INTERVAL_W + 1;
	localparam int TARGET_W   = 8;
	localparam int TC_W       = TARGET_W + FILL_W;
	localparam int TEMP_W     = 18;
	localparam int CAP_W      = 8;
	localparam int DIV_CNT_W  = $clog2(SAMPLE_W);
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = INTERVAL_W;

	localparam logic [SAMPLE_W-1:0] RATE_DIVIDEND = SAMPLE_W'(32'd256000000);

	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_ENABLE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ADAPTIVE_ENABLE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RATE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_INTERVAL = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ADJUST_INTERVAL = 3'd4;

	localparam logic [TARGET_W-1:0]   TARGET_RESET          = 8'd60;
	localparam logic [INTERVAL_W-1:0] SENSOR_INTERVAL_RESET = 26'd2000000;
	localparam logic [INTERVAL_W-1:0] ADJUST_INTERVAL_RESET = 26'd1000000;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_SUSPEND = 2'd1;
	localparam logic [1:0] MODE_RESUME  = 2'd2;

	localparam logic [1:0] LVL_LOW  = 2'd0;
	localparam logic [1:0] LVL_MED  = 2'd1;
	localparam logic [1:0] LVL_HIGH = 2'd2;

	localparam logic [1:0] TH_COOL     = 2'd0;
	localparam logic [1:0] TH_WARM     = 2'd1;
	localparam logic [1:0] TH_HOT      = 2'd2;
	localparam logic [1:0] TH_CRITICAL = 2'd3;

	localparam logic [TEMP_W-1:0] TEMP_WARM     = 18'd65000;
	localparam logic [TEMP_W-1:0] TEMP_HOT      = 18'd80000;
	localparam logic [TEMP_W-1:0] TEMP_CRITICAL = 18'd95000;

	localparam logic [CAP_W-1:0] BATTERY_MAX = 8'd100;
	localparam logic [CAP_W-1:0] BATTERY_LOW = 8'd15;
	localparam logic [CAP_W-1:0] BATTERY_NONE = 8'hFF;

	localparam logic [11:0] SHADOW_LOW  = 12'd512;
	localparam logic [11:0] SHADOW_MED  = 12'd1024;
	localparam logic [11:0] SHADOW_HIGH = 12'd2048;
	localparam logic [13:0] PARTICLE_LOW  = 14'd2048;
	localparam logic [13:0] PARTICLE_MED  = 14'd4096;
	localparam logic [13:0] PARTICLE_HIGH = 14'd8192;
	localparam logic [8:0]  SCALE_LOW  = 9'd166;
	localparam logic [8:0]  SCALE_MED  = 9'd205;
	localparam logic [8:0]  SCALE_HIGH = 9'd256;

	typedef struct packed {
		logic [1:0]        mode;
		logic [FT_W-1:0]   frame_time_us;
		logic [TEMP_W-1:0] hottest_temp_mc;
		logic              battery_present;
		logic [CAP_W-1:0]  battery_capacity;
		logic              battery_charging;
	} aqg_item_t;

	typedef struct packed {
		logic [1:0]        quality_level;
		logic [1:0]        thermal_level;
		logic [11:0]       shadow_map_size;
		logic [13:0]       particle_limit;
		logic [8:0]        render_scale_q8;
		logic              quality_changed;
		logic              quality_raised;
		logic signed [7:0] battery_level;
	} aqg_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_PUSH,
		ST_ADJ,
		ST_PREP,
		ST_DECIDE,
		ST_DONE
	} aqg_state_t;

	typedef struct packed {
		logic capture;
		logic tick;
		logic suspend;
		logic resume;
		logic div_start;
		logic push;
		logic prep;
		logic decide;
		logic load_out;
	} aqg_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       enabled;
		logic       suspended;
		logic       ft_zero;
		logic       adj_fire;
		logic       div_done;
		logic       out_busy;
	} aqg_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/adaptive_quality_governor.sv
// Top level of the adaptive quality governor: controller plus datapath.
// Depends on aqg_pkg, aqg_ctrl and aqg_datapath.
//
// Channel   Handshake                     Payload
// item      item_valid / item_ready       item_data (aqg_item_t)
// result    result_valid / result_ready   result_data (aqg_result_t)
// cfg       cfg_valid / cfg_ready         cfg_index, cfg_data
//
// A frame tick with a nonzero frame time passes decode, the bit-serial divider, push and
// adjust, plus prepare and decide if the quality is adjusted, then registers its result.
// A zero-time tick skips the divider and push, any other beat goes to done; the next item
// beat is taken in the idle state after the result is registered. A result beat held by a low
// result_ready stalls the following item's result in the last state. cfg_ready is always high.
// Reset is asynchronous; a fill count covers the rate history, so it needs no clearing pass.
`default_nettype none

module adaptive_quality_governor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire aqg_pkg::aqg_item_t              item_data,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output aqg_pkg::aqg_result_t                 result_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [aqg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [aqg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import aqg_pkg::*;

	aqg_cmd_t cmd;
	aqg_sts_t sts;

	assign cfg_ready = 1'b1;

	aqg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	aqg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item_data    (item_data),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

`default_nettype wire

>>> hw/rtl/aqg_div.sv
// Restoring divider for the frame-rate sample, one quotient bit per cycle.
// Depends on aqg_pkg.
`default_nettype none

module aqg_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [aqg_pkg::FT_W-1:0]     divisor,
	output logic                              done,
	output logic [aqg_pkg::SAMPLE_W-1:0]      quotient
);
	import aqg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FT_W-1:0]      rem_q;
	logic [FT_W-1:0]      div_q;
	logic [SAMPLE_W-1:0]  quo_q;
	logic [FT_W:0]        trial;
	logic [FT_W:0]        diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[SAMPLE_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(SAMPLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= RATE_DIVIDEND;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FT_W-1:0] : trial[FT_W-1:0];
			quo_q <= {quo_q[SAMPLE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/aqg_datapath.sv
// Datapath of the governor: registers, timers, rate history memory, level decision.
// Depends on aqg_pkg and aqg_div; driven by commands from aqg_ctrl.
`default_nettype none

module aqg_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire aqg_pkg::aqg_cmd_t               cmd,
	output aqg_pkg::aqg_sts_t                    sts,
	input  wire aqg_pkg::aqg_item_t              item_data,
	input  wire logic                            cfg_valid,
	input  wire logic [aqg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [aqg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output aqg_pkg::aqg_result_t                 result_data
);
	import aqg_pkg::*;

	// Configuration.
	logic                  block_enable_q;
	logic                  adaptive_enable_q;
	logic [TARGET_W-1:0]   target_q;
	logic [INTERVAL_W-1:0] sensor_int_q;
	logic [INTERVAL_W-1:0] adjust_int_q;

	// Governor state.
	aqg_item_t          item_q;
	logic [TIMER_W-1:0] sensor_timer_q;
	logic [TIMER_W-1:0] adjust_timer_q;
	logic               adj_fire_q;
	logic [1:0]         level_q;
	logic [1:0]         thermal_q;
	logic [7:0]         battery_q;
	logic               charging_q;
	logic               suspended_q;
	logic               latched_q;
	logic               changed_q;
	logic               raised_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SUM_W-1:0]   sum_q;

	// Decision pipeline.
	logic [TC_W-1:0]  tc_q;
	logic [CMP_W-1:0] s20_q;
	logic [CMP_W-1:0] s10_q;
	logic [1:0]       lv_cap_q;

	logic [SAMPLE_W-1:0] hist_mem [WINDOW];
	logic [SAMPLE_W-1:0] rd_q;

	aqg_result_t result_q;
	logic        result_valid_q;

	logic [SAMPLE_W-1:0] sample;
	logic                div_done;
	logic [TIMER_W-1:0]  sensor_sum;
	logic [TIMER_W-1:0]  adjust_sum;
	logic                sensor_exp;
	logic                adjust_exp;
	logic                latch_en;
	logic [1:0]          thermal_new;
	logic [7:0]          battery_new;
	logic                charging_new;
	logic [SAMPLE_W-1:0] old_sample;
	logic [CMP_W-1:0]    r17;
	logic [CMP_W-1:0]    r11;
	logic [1:0]          lv_step;
	logic [1:0]          lv_new;
	logic                bat_low;
	logic                out_busy;

	aqg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (item_q.frame_time_us),
		.done     (div_done),
		.quotient (sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_enable_q    <= 1'b0;
			adaptive_enable_q <= 1'b1;
			target_q          <= TARGET_RESET;
			sensor_int_q      <= SENSOR_INTERVAL_RESET;
			adjust_int_q      <= ADJUST_INTERVAL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_ENABLE:    block_enable_q    <= cfg_data[0];
				REG_ADAPTIVE_ENABLE: adaptive_enable_q <= cfg_data[0];
				REG_TARGET_RATE:     target_q          <= cfg_data[TARGET_W-1:0];
				REG_SENSOR_INTERVAL: sensor_int_q      <= cfg_data;
				REG_ADJUST_INTERVAL: adjust_int_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_data;
		end
	end

	assign sensor_sum = sensor_timer_q + TIMER_W'(item_q.frame_time_us);
	assign adjust_sum = adjust_timer_q + TIMER_W'(item_q.frame_time_us);
	assign sensor_exp = (sensor_sum >= TIMER_W'(sensor_int_q));
	assign adjust_exp = (adjust_sum >= TIMER_W'(adjust_int_q));
	assign latch_en   = cmd.resume || (cmd.tick && (sensor_exp || !latched_q));

	always_comb begin
		if (item_q.hottest_temp_mc < TEMP_WARM) begin
			thermal_new = TH_COOL;
		end else if (item_q.hottest_temp_mc < TEMP_HOT) begin
			thermal_new = TH_WARM;
		end else if (item_q.hottest_temp_mc < TEMP_CRITICAL) begin
			thermal_new = TH_HOT;
		end else begin
			thermal_new = TH_CRITICAL;
		end
		if (item_q.battery_present) begin
			battery_new  = (item_q.battery_capacity > BATTERY_MAX) ? BATTERY_MAX
				: item_q.battery_capacity;
			charging_new = item_q.battery_charging;
		end else begin
			battery_new  = BATTERY_NONE;
			charging_new = 1'b0;
		end
	end

	assign old_sample = (fill_q == FILL_W'(WINDOW)) ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hist_mem[ptr_q] <= sample;
		end
		rd_q <= hist_mem[ptr_q];
	end

	// Decision compare: sum*20 against 17*256*target*count, sum*10 against 11*256*...
	assign r17 = (CMP_W'(tc_q) << 12) + (CMP_W'(tc_q) << 8);
	assign r11 = (CMP_W'(tc_q) << 11) + (CMP_W'(tc_q) << 9) + (CMP_W'(tc_q) << 8);
	assign bat_low = !battery_q[7] && (battery_q < BATTERY_LOW);

	always_comb begin
		lv_step = lv_cap_q;
		if (fill_q != '0) begin
			if (s20_q < r17) begin
				if (lv_cap_q == LVL_HIGH) begin
					lv_step = LVL_MED;
				end else if (lv_cap_q == LVL_MED) begin
					lv_step = LVL_LOW;
				end
			end else if ((s10_q > r11) && (thermal_q == TH_COOL || thermal_q == TH_WARM)) begin
				if (lv_cap_q == LVL_LOW) begin
					lv_step = LVL_MED;
				end else if (lv_cap_q == LVL_MED) begin
					lv_step = LVL_HIGH;
				end
			end
		end
		lv_new = (bat_low && !charging_q && lv_step == LVL_HIGH) ? LVL_MED : lv_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_timer_q <= '0;
			adjust_timer_q <= '0;
			adj_fire_q     <= 1'b0;
			level_q        <= LVL_MED;
			thermal_q      <= TH_COOL;
			battery_q      <= BATTERY_NONE;
			charging_q     <= 1'b0;
			suspended_q    <= 1'b0;
			latched_q      <= 1'b0;
			changed_q      <= 1'b0;
			raised_q       <= 1'b0;
			ptr_q          <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
		end else begin
			if (cmd.capture) begin
				changed_q  <= 1'b0;
				raised_q   <= 1'b0;
				adj_fire_q <= 1'b0;
			end
			if (cmd.tick) begin
				sensor_timer_q <= sensor_exp ? '0 : sensor_sum;
				if (adaptive_enable_q) begin
					adjust_timer_q <= adjust_exp ? '0 : adjust_sum;
					adj_fire_q     <= adjust_exp;
				end else begin
					adj_fire_q <= 1'b0;
				end
			end
			if (latch_en) begin
				thermal_q  <= thermal_new;
				battery_q  <= battery_new;
				charging_q <= charging_new;
				latched_q  <= 1'b1;
			end
			if (cmd.suspend) begin
				suspended_q <= 1'b1;
			end
			if (cmd.resume) begin
				suspended_q <= 1'b0;
				ptr_q       <= '0;
				fill_q      <= '0;
				sum_q       <= '0;
			end
			if (cmd.push) begin
				sum_q <= sum_q - SUM_W'(old_sample) + SUM_W'(sample);
				ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.decide) begin
				level_q <= lv_new;
				if (lv_new != level_q) begin
					changed_q <= 1'b1;
					raised_q  <= (lv_new > level_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			tc_q  <= TC_W'(TC_W'(target_q) * TC_W'(fill_q));
			s20_q <= (CMP_W'(sum_q) << 4) + (CMP_W'(sum_q) << 2);
			s10_q <= (CMP_W'(sum_q) << 3) + (CMP_W'(sum_q) << 1);
			if (thermal_q == TH_CRITICAL) begin
				lv_cap_q <= LVL_LOW;
			end else if (thermal_q == TH_HOT && level_q == LVL_HIGH) begin
				lv_cap_q <= LVL_MED;
			end else begin
				lv_cap_q <= level_q;
			end
		end
	end

	assign out_busy = result_valid_q && !result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.quality_level   <= level_q;
			result_q.thermal_level   <= thermal_q;
			result_q.quality_changed <= changed_q;
			result_q.quality_raised  <= raised_q;
			result_q.battery_level   <= $signed(battery_q);
			case (level_q)
				LVL_LOW: begin
					result_q.shadow_map_size <= SHADOW_LOW;
					result_q.particle_limit  <= PARTICLE_LOW;
					result_q.render_scale_q8 <= SCALE_LOW;
				end
				LVL_HIGH: begin
					result_q.shadow_map_size <= SHADOW_HIGH;
					result_q.particle_limit  <= PARTICLE_HIGH;
					result_q.render_scale_q8 <= SCALE_HIGH;
				end
				default: begin
					result_q.shadow_map_size <= SHADOW_MED;
					result_q.particle_limit  <= PARTICLE_MED;
					result_q.render_scale_q8 <= SCALE_MED;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign sts.mode      = item_q.mode;
	assign sts.enabled   = block_enable_q;
	assign sts.suspended = suspended_q;
	assign sts.ft_zero   = (item_q.frame_time_us == '0);
	assign sts.adj_fire  = adj_fire_q;
	assign sts.div_done  = div_done;
	assign sts.out_busy  = out_busy;

endmodule

`default_nettype wire

>>> hw/rtl/aqg_ctrl.sv
// Controller state machine of the governor; sequences one item through the datapath.
// Depends on aqg_pkg.
`default_nettype none

module aqg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire aqg_pkg::aqg_sts_t sts,
	output aqg_pkg::aqg_cmd_t      cmd
);
	import aqg_pkg::*;

	aqg_state_t state_q;
	aqg_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.enabled && sts.mode == MODE_TICK) begin
					state_nx = sts.ft_zero ? ST_ADJ : ST_DIV;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nx = ST_PUSH;
				end
			end
			ST_PUSH:   state_nx = ST_ADJ;
			ST_ADJ:    state_nx = sts.adj_fire ? ST_PREP : ST_DONE;
			ST_PREP:   state_nx = ST_DECIDE;
			ST_DECIDE: state_nx = ST_DONE;
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ST_DECODE: begin
				if (sts.enabled) begin
					case (sts.mode)
						MODE_TICK: begin
							cmd.tick      = 1'b1;
							cmd.div_start = !sts.ft_zero;
						end
						MODE_SUSPEND: cmd.suspend = 1'b1;
						MODE_RESUME:  cmd.resume  = sts.suspended;
						default: begin
						end
					endcase
				end
			end
			ST_PUSH:   cmd.push   = 1'b1;
			ST_PREP:   cmd.prep   = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_DONE:   cmd.load_out = !sts.out_busy;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
